>>> sv/wfd_pkg.sv
// Shared types and constants for the wall follower turn decider.
// No dependencies; imported by every module of the block.
package wfd_pkg;

  // Motion command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_FWD   = 3'd1;
  localparam logic [2:0] CMD_RIGHT = 3'd2;
  localparam logic [2:0] CMD_LEFT  = 3'd3;
  localparam logic [2:0] CMD_BACK  = 3'd4;

  // Pending turn codes (code 3 is unused, acts as none)
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_RIGHT = 2'd1;
  localparam logic [1:0] PEND_LEFT  = 2'd2;

  // Dead-end scan phases (code 3 is unused, acts as none)
  localparam logic [1:0] SCAN_NONE        = 2'd0;
  localparam logic [1:0] SCAN_TURNED_RIGHT = 2'd1;
  localparam logic [1:0] SCAN_TURNED_BACK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FRONT_BLOCK = 2'd0;
  localparam logic [1:0] REG_SIDE_HIGH   = 2'd1;
  localparam logic [1:0] REG_SIDE_LOW    = 2'd2;
  localparam logic [1:0] REG_SETTLE      = 2'd3;

  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int IN_W   = 97;
  localparam int IN_TDATA_W  = 104;
  localparam int RES_W  = 9;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic [15:0] front_block_mm;
    logic [15:0] side_open_high_mm;
    logic [15:0] side_open_low_mm;
    logic [15:0] settle_wait_ms;
  } cfg_t;

  // Packed so that front_left_mm lands in the lowest bits
  typedef struct packed {
    logic [31:0] now_ms;
    logic        motion_busy;
    logic [15:0] right_mm;
    logic [15:0] left_mm;
    logic [15:0] front_right_mm;
    logic [15:0] front_left_mm;
  } in_t;

  // Packed so that command lands in the lowest bits
  typedef struct packed {
    logic       right_open;
    logic       left_open;
    logic       front_blocked;
    logic       evaluated;
    logic [1:0] heading;
    logic [2:0] command;
  } res_t;

  typedef struct packed {
    logic [1:0]  heading_dir;
    logic [1:0]  pending_turn;
    logic        right_open;
    logic        left_open;
    logic        waiting;
    logic [31:0] stop_time;
    logic [1:0]  scan_phase;
  } state_t;

endpackage

>>> sv/wfd_cfg_regs.sv
// Configuration register file of the wall follower turn decider.
// Depends on wfd_pkg for the register indexes and cfg_t.
module wfd_cfg_regs import wfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_block_mm    <= 16'd165;
      cfg.side_open_high_mm <= 16'd250;
      cfg.side_open_low_mm  <= 16'd170;
      cfg.settle_wait_ms    <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRONT_BLOCK: cfg.front_block_mm    <= cfg_data;
        REG_SIDE_HIGH:   cfg.side_open_high_mm <= cfg_data;
        REG_SIDE_LOW:    cfg.side_open_low_mm  <= cfg_data;
        REG_SETTLE:      cfg.settle_wait_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/wfd_core.sv
// Decision logic: settle timer, wall classification, scan and right-hand rule.
// Pure combinational next-state and result; depends on wfd_pkg.
module wfd_core import wfd_pkg::*; (
  input  cfg_t   cfg,
  input  in_t    din,
  input  state_t st,
  output state_t st_next,
  output res_t   res
);

  logic [31:0] elapsed;
  logic        settled;
  logic [15:0] front;
  logic        fblk;
  logic        ropen;
  logic        lopen;
  logic [2:0]  cmd;
  logic [1:0]  pend;
  logic        use_rule;

  assign elapsed = din.now_ms - st.stop_time;
  assign settled = elapsed >= {16'd0, cfg.settle_wait_ms};
  assign front   = (din.front_left_mm > din.front_right_mm) ? din.front_left_mm
                                                            : din.front_right_mm;
  assign fblk    = front < cfg.front_block_mm;
  assign ropen   = st.right_open ? (din.right_mm > cfg.side_open_low_mm)
                                 : (din.right_mm > cfg.side_open_high_mm);
  assign lopen   = st.left_open  ? (din.left_mm > cfg.side_open_low_mm)
                                 : (din.left_mm > cfg.side_open_high_mm);

  // Scan step or right-hand rule; produces cmd, pend and next scan phase
  always_comb begin
    st_next  = st;
    res      = '0;
    cmd      = CMD_NONE;
    pend     = PEND_NONE;
    use_rule = 1'b0;

    if (din.motion_busy) begin
      st_next.waiting = 1'b0;
    end else if (!st.waiting) begin
      st_next.stop_time = din.now_ms;
      st_next.waiting   = 1'b1;
    end else if (settled) begin
      st_next.right_open = ropen;
      st_next.left_open  = lopen;
      st_next.waiting    = 1'b0;
      st_next.scan_phase = SCAN_NONE;
      pend               = st.pending_turn;

      if (st.scan_phase == SCAN_TURNED_RIGHT) begin
        if (!fblk) begin
          use_rule = 1'b1;
        end else begin
          st_next.scan_phase = SCAN_TURNED_BACK;
          cmd                = CMD_BACK;
        end
      end else if (st.scan_phase == SCAN_TURNED_BACK) begin
        if (!fblk) use_rule = 1'b1;
        else cmd = CMD_LEFT;
      end else if (fblk && !lopen && !ropen) begin
        pend               = PEND_NONE;
        st_next.scan_phase = SCAN_TURNED_RIGHT;
        cmd                = CMD_RIGHT;
      end else begin
        use_rule = 1'b1;
      end

      if (use_rule) begin
        // Right-hand rule; a pending turn from the last step goes first
        pend = PEND_NONE;
        if (st.pending_turn == PEND_RIGHT) begin
          cmd = CMD_RIGHT;
        end else if (st.pending_turn == PEND_LEFT) begin
          cmd = CMD_LEFT;
        end else if (ropen) begin
          pend = PEND_RIGHT;
          cmd  = CMD_FWD;
        end else if (!fblk) begin
          cmd = CMD_FWD;
        end else if (lopen) begin
          pend = PEND_LEFT;
          cmd  = CMD_FWD;
        end else begin
          cmd = CMD_BACK;
        end
      end
      st_next.pending_turn = pend;

      case (cmd)
        CMD_RIGHT: st_next.heading_dir = st.heading_dir + 2'd1;
        CMD_LEFT:  st_next.heading_dir = st.heading_dir + 2'd3;
        CMD_BACK:  st_next.heading_dir = st.heading_dir + 2'd2;
        default:   st_next.heading_dir = st.heading_dir;
      endcase

      res.evaluated     = 1'b1;
      res.front_blocked = fblk;
      res.left_open     = lopen;
      res.right_open    = ropen;
      res.command       = cmd;
    end
    res.heading = st_next.heading_dir;
  end

endmodule

>>> sv/wall_follower_turn_decider.sv
// Wall follower turn decider, top level.
// A beat accepted into the input register passes through the decision logic into the result
// register. Throughput: one beat per cycle while m_tready does not stall the output,
// bounded by the update of the decision state feeding the next beat.
// Reset (rst, synchronous): pipe empty, decision state zero, config registers at
// 165 / 250 / 170 / 50. Depends on wfd_pkg, wfd_cfg_regs and wfd_core.
module wall_follower_turn_decider import wfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Sample stream in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [15:0] front_left_mm, [31:16] front_right_mm, [47:32] left_mm,
  // [63:48] right_mm, [64] motion_busy, [96:65] now_ms, [103:97] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Decision stream out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] command, [4:3] heading, [5] evaluated, [6] front_blocked,
  // [7] left_open, [8] right_open, [15:9] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_idx,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_t   cfg;
  in_t    s1_data;
  logic   s1_valid;
  state_t st;
  state_t st_next;
  res_t   res;
  res_t   res_q;
  logic   adv;    // result register can take a new beat
  logic   fire;   // stage-1 beat moves into the result register

  wfd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  wfd_core u_core (
    .cfg     (cfg),
    .din     (s1_data),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // Pipe moves whenever the output slot is empty or being drained; the input
  // register refills in the same cycle, so back-to-back beats flow freely.
  assign adv      = !m_tvalid || m_tready;
  assign fire     = s1_valid && adv;
  assign s_tready = !s1_valid || adv;
  assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, res_q};

  // Control and decision state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_tready) s1_valid <= s_tvalid;
      if (adv)      m_tvalid <= s1_valid;
      if (fire)     st       <= st_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) s1_data <= in_t'(s_tdata[IN_W-1:0]);
    if (fire)                 res_q   <= res;
  end

  // A forward or idle step never turns the robot
  a_fwd_keeps_heading: assert property (@(posedge clk) disable iff (rst)
    fire && res.command != CMD_RIGHT && res.command != CMD_LEFT
      && res.command != CMD_BACK |=> st.heading_dir == $past(st.heading_dir))
    else $error("heading changed without a turn command");

  // A decision always ends the settle wait
  a_eval_clears_wait: assert property (@(posedge clk) disable iff (rst)
    fire && res.evaluated |=> !st.waiting)
    else $error("settle wait still armed after a decision");

  // No command unless the walls were evaluated
  a_cmd_needs_eval: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res_q.evaluated |-> res_q.command == CMD_NONE)
    else $error("command issued without evaluation");

  // Decision state only moves when a beat passes through
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> st == $past(st))
    else $error("decision state changed without a beat");

  // A stalled stage-1 beat is neither lost nor altered
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && s1_data == $past(s1_data))
    else $error("stage-1 beat lost under stall");

endmodule
